// File: rtl/core/bilevel_blank_page_detector_macros.svh
// Assertion macros used by the checker of the blank page detector.
`ifndef BILEVEL_BLANK_PAGE_DETECTOR_MACROS_SVH
`define BILEVEL_BLANK_PAGE_DETECTOR_MACROS_SVH

// Checked only outside reset.
`define BBPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BBPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bbpd_pkg.sv
package bbpd_pkg;

  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned MAX_HEIGHT = 8192;

  localparam logic [26:0] COUNT_MAX = 27'h7FF_FFFF;
  // 100 percent in Q8 units
  localparam logic [14:0] PCT_SCALE = 15'd25600;

  localparam logic [13:0] WIDTH_RST  = 14'd2480;
  localparam logic [13:0] HEIGHT_RST = 14'd3508;
  localparam logic [12:0] MARGIN_RST = 13'd0;
  localparam logic [14:0] THR_RST    = 15'd256;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MARGIN = 2'd2,
    CFG_THR    = 2'd3
  } bbpd_cfg_idx_t;

  typedef struct packed {
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic [12:0] margin_pixels;
    logic [14:0] threshold_q8;
  } bbpd_cfg_t;

  // One classified byte: dark pixels that count, and end of frame
  typedef struct packed {
    logic [3:0] add;
    logic       last;
  } bbpd_item_t;

  function automatic logic [13:0] eff_width(input logic [13:0] w);
    logic [13:0] r;
    r = w;
    if (w == 14'd0) r = 14'd1;
    else if (w > 14'(MAX_WIDTH)) r = 14'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [13:0] eff_height(input logic [13:0] h);
    logic [13:0] r;
    r = h;
    if (h == 14'd0) r = 14'd1;
    else if (h > 14'(MAX_HEIGHT)) r = 14'(MAX_HEIGHT);
    return r;
  endfunction

endpackage

// File: rtl/core/bilevel_blank_page_detector.sv
// Bytes are taken at one per cycle while the 4-entry queue between the front and back has room.
// With the queue empty and the output free, out_valid rises once the transfer of a frame's
// last byte has passed the queue, accumulate, two multiply stages and compare into output reg.
// Each frame end leaves the back without pops through MUL1, MUL2 and OUT, longer if the output
// stalls; with bytes back to back the queue fills and the input stalls at frame ends.
// Reset (rst_n low, synchronous) clears position, count, queue, output valid; loads defaults.
module bilevel_blank_page_detector
  import bbpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [26:0] out_dark_pixel_count,
  output logic        out_page_is_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bbpd_cfg_t  cfg_r, cfg_nxt;
  bbpd_item_t push_item, pop_item;
  logic       q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (bbpd_cfg_idx_t'(cfg_index))
        CFG_WIDTH:  cfg_nxt.image_width   = cfg_data[13:0];
        CFG_HEIGHT: cfg_nxt.image_height  = cfg_data[13:0];
        CFG_MARGIN: cfg_nxt.margin_pixels = cfg_data[12:0];
        CFG_THR:    cfg_nxt.threshold_q8  = cfg_data[14:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= WIDTH_RST;
      cfg_r.image_height  <= HEIGHT_RST;
      cfg_r.margin_pixels <= MARGIN_RST;
      cfg_r.threshold_q8  <= THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bbpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_byte (in_pixel_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  bbpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  bbpd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (pop_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_dark_pixel_count (out_dark_pixel_count),
    .out_page_is_empty    (out_page_is_empty)
  );

endmodule

// File: rtl/core/bbpd_front.sv
module bbpd_front
  import bbpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bbpd_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_byte,
  input  logic        q_full,
  output logic        q_push,
  output bbpd_item_t  q_item
);

  logic [12:0] row_r, row_nxt;
  logic [9:0]  col_r, col_nxt;

  logic [13:0] w_eff, h_eff;
  logic [10:0] stride;
  logic [12:0] m;
  logic [9:0]  mb;
  logic [14:0] w_sum;
  logic        row_in, col_in, col_end, row_end;
  logic [3:0]  dark;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    w_eff   = eff_width(cfg.image_width);
    h_eff   = eff_height(cfg.image_height);
    w_sum   = {1'b0, w_eff} + 15'd7;
    stride  = w_sum[13:3];
    m       = {cfg.margin_pixels[12:3], 3'b000};
    mb      = cfg.margin_pixels[12:3];
    row_in  = (row_r >= m) && (({2'b00, row_r} + {2'b00, m}) < {1'b0, h_eff});
    col_in  = (col_r >= mb) && (({2'b00, col_r} + {2'b00, mb}) < {1'b0, stride});
    col_end = ({1'b0, col_r} + 11'd1) >= stride;
    row_end = ({1'b0, row_r} + 14'd1) >= h_eff;
    dark = 4'd0;
    for (int i = 0; i < 8; i++) begin
      dark = dark + {3'b000, ~in_pixel_byte[i]};
    end
    q_item.add  = (row_in && col_in) ? dark : 4'd0;
    q_item.last = col_end && row_end;

    row_nxt = row_r;
    col_nxt = col_r;
    if (q_push) begin
      if (col_end) begin
        col_nxt = 10'd0;
        row_nxt = row_end ? 13'd0 : row_r + 13'd1;
      end else begin
        col_nxt = col_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: rtl/core/bbpd_queue.sv
module bbpd_queue
  import bbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bbpd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       pop_valid,
  output bbpd_item_t pop_item
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  bbpd_item_t      mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_pop;

  assign full      = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_item  = mem_r[rd_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/bbpd_back.sv
module bbpd_back
  import bbpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bbpd_cfg_t   cfg,
  input  logic        q_valid,
  input  bbpd_item_t  q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [26:0] out_dark_pixel_count,
  output logic        out_page_is_empty
);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_OUT  = 4'b1000
  } bbpd_state_t;

  bbpd_state_t state_r, state_nxt;
  logic [26:0] total_r, total_nxt;
  logic [26:0] res_r, res_nxt;
  logic [42:0] lhs_r, lhs_nxt;
  logic [27:0] wh_r, wh_nxt;
  logic [42:0] rhs_r, rhs_nxt;
  logic        ov_r, ov_nxt;
  logic [26:0] cnt_r, cnt_nxt;
  logic        empty_r, empty_nxt;
  logic [27:0] sum;
  logic [26:0] sat;

  assign out_valid            = ov_r;
  assign out_dark_pixel_count = cnt_r;
  assign out_page_is_empty    = empty_r;

  always_comb begin
    sum       = {1'b0, total_r} + {24'd0, q_item.add};
    sat       = sum[27] ? COUNT_MAX : sum[26:0];
    state_nxt = state_r;
    total_nxt = total_r;
    res_nxt   = res_r;
    lhs_nxt   = lhs_r;
    wh_nxt    = wh_r;
    rhs_nxt   = rhs_r;
    ov_nxt    = ov_r && !out_ready;
    cnt_nxt   = cnt_r;
    empty_nxt = empty_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        q_pop = q_valid;
        if (q_valid) begin
          if (q_item.last) begin
            res_nxt   = sat;
            total_nxt = '0;
            state_nxt = ST_MUL1;
          end else begin
            total_nxt = sat;
          end
        end
      end
      ST_MUL1: begin
        lhs_nxt   = {16'd0, res_r} * {28'd0, PCT_SCALE};
        wh_nxt    = {14'd0, eff_width(cfg.image_width)} *
                    {14'd0, eff_height(cfg.image_height)};
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        rhs_nxt   = {28'd0, cfg.threshold_q8} * {15'd0, wh_r};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          cnt_nxt   = res_r;
          empty_nxt = lhs_r < rhs_r;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    lhs_r   <= lhs_nxt;
    wh_r    <= wh_nxt;
    rhs_r   <= rhs_nxt;
    cnt_r   <= cnt_nxt;
    empty_r <= empty_nxt;
  end

endmodule

// File: rtl/core/bbpd_checker.sv
`include "bilevel_blank_page_detector_macros.svh"

module bbpd_checker
  import bbpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [26:0] out_dark_pixel_count,
  input logic        out_page_is_empty,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // shadow of the threshold register, seen through the config port
  logic [14:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_valid && cfg_ready && (bbpd_cfg_idx_t'(cfg_index) == CFG_THR)) begin
      thr_r <= cfg_data[14:0];
    end
  end

  `BBPD_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `BBPD_ASSERT_ALWAYS(a_rst_ready, !rst_n |=> in_ready, "input not ready after reset")
  `BBPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_dark_pixel_count) && $stable(out_page_is_empty), "stalled result changed")
  `BBPD_ASSERT(a_blank_empty, out_valid && (out_dark_pixel_count == 27'd0) && (thr_r != 15'd0) |-> out_page_is_empty, "blank page not flagged")
  `BBPD_ASSERT(a_zero_thr, out_valid && (thr_r == 15'd0) |-> !out_page_is_empty, "zero threshold flagged empty")

endmodule

bind bilevel_blank_page_detector bbpd_checker u_bbpd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_dark_pixel_count (out_dark_pixel_count),
  .out_page_is_empty    (out_page_is_empty),
  .cfg_valid            (cfg_valid),
  .cfg_ready            (cfg_ready),
  .cfg_index            (cfg_index),
  .cfg_data             (cfg_data)
);
